// ===== rtl/bfws_pkg.sv =====
// bfws_pkg: shared types and codes of the bounded fifo with search
// used by the front, the executor and the top level; depends on nothing
package bfws_pkg;

  // command kinds as carried on the input tuser
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_STAT = 2'd2,
    CMD_SRCH = 2'd3
  } cmd_kind_t;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // reset value of the fill limit
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  // executor states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DEQ_RD,
    BK_SCAN
  } back_state_t;

  // one result beat, read_value in the lowest bits
  typedef struct packed {
    logic        is_empty;
    logic [4:0]  entry_count;
    logic        found;
    logic [1:0]  status;
    logic [31:0] read_value;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);
  localparam int RESULT_PAD  = 48 - RESULT_BITS;

endpackage

// ===== rtl/bfws_ram.sv =====
// bfws_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module bfws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bfws_front.sv =====
// bfws_front: accepts command beats, decodes them and holds the fill limit
// depends on bfws_pkg
module bfws_front #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int LW         = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  // command input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // value
  input  logic [1:0]                s_axis_tuser,   // op
  // limit register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [4:0]                cfg_data,
  // decoded command toward the queue
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output bfws_pkg::cmd_kind_t       cmd_kind,
  output logic [DATA_WIDTH-1:0]     cmd_value,
  // effective limit, never above the depth
  output logic [LW-1:0]             limit_eff
);
  import bfws_pkg::*;

  logic [4:0]             queue_limit;
  logic [LW+4:0]          limit_ext;
  logic [DATA_WIDTH+31:0] value_ext;

  // limit register, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      queue_limit <= cfg_data;
    end
  end

  // clamp the limit to the store depth
  assign limit_ext = {{LW{1'b0}}, queue_limit};
  assign limit_eff = (limit_ext[LW-1:0] > LW'(DEPTH)) ? LW'(DEPTH) : limit_ext[LW-1:0];

  // value kept in its low data-width bits
  assign value_ext = {{DATA_WIDTH{1'b0}}, s_axis_tdata};

  // input register stage
  assign s_axis_tready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_axis_tready) begin
      cmd_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_kind  <= cmd_kind_t'(s_axis_tuser);
      cmd_value <= value_ext[DATA_WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/bfws_cmd_queue.sv =====
// bfws_cmd_queue: two-entry command queue between the front and the executor
// depends on nothing
module bfws_cmd_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slot[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_data;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("command queue over two entries");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (fill == $past(fill) - 2'd1))
    else $error("command queue fill did not drop on pop");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !push)
    else $error("push into a full command queue");

endmodule

// ===== rtl/bfws_back.sv =====
// bfws_back: executes commands on the ring store and registers each result
// depends on bfws_pkg and bfws_ram
module bfws_back #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int LW         = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  bfws_pkg::cmd_kind_t   cmd_kind,
  input  logic [DATA_WIDTH-1:0] cmd_value,
  input  logic [LW-1:0]         limit_eff,
  output logic                  res_valid,
  input  logic                  res_ready,
  output bfws_pkg::result_t     res
);
  import bfws_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  back_state_t           state, state_next;
  logic [AW-1:0]         head, head_next;
  logic [AW-1:0]         tail, tail_next;
  logic [CW-1:0]         occ, occ_next;
  logic [AW-1:0]         scan_idx, scan_idx_next;
  logic [CW-1:0]         scan_cnt, scan_cnt_next;
  logic                  rd_pend, rd_pend_next;
  logic                  hit, hit_next;
  logic [DATA_WIDTH-1:0] key, key_next;
  logic                  res_load;
  result_t               res_next;
  logic                  out_free;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [DATA_WIDTH+31:0] rdata_ext;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
    advance = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic result_t make_result(input logic [31:0] rd, input logic [1:0] st,
                                          input logic fnd, input logic [CW-1:0] cnt);
    logic [CW+4:0] cnt_ext;
    cnt_ext                 = {5'b0, cnt};
    make_result.read_value  = rd;
    make_result.status      = st;
    make_result.found       = fnd;
    make_result.entry_count = cnt_ext[4:0];
    make_result.is_empty    = (cnt == '0);
  endfunction

  bfws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (cmd_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rdata_ext = {32'b0, ram_rdata};
  assign out_free  = !res_valid || res_ready;

  // state register and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      head    <= '0;
      tail    <= '0;
      occ     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      occ     <= occ_next;
      rd_pend <= rd_pend_next;
    end
  end

  // search working registers
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    scan_cnt <= scan_cnt_next;
    hit      <= hit_next;
    key      <= key_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // next state and command execution
  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    occ_next      = occ;
    scan_idx_next = scan_idx;
    scan_cnt_next = scan_cnt;
    rd_pend_next  = 1'b0;
    hit_next      = hit;
    key_next      = key;
    res_load      = 1'b0;
    res_next      = make_result(32'd0, ST_OK, 1'b0, occ);
    cmd_ready     = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = head;

    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          unique case (cmd_kind)
            CMD_ENQ: begin
              res_load = 1'b1;
              if (LW'(occ) >= limit_eff) begin
                res_next = make_result(32'd0, ST_FULL, 1'b0, occ);
              end else begin
                ram_we    = 1'b1;
                tail_next = advance(tail);
                occ_next  = occ + 1'b1;
                res_next  = make_result(32'd0, ST_OK, 1'b0, occ + 1'b1);
              end
            end
            CMD_DEQ: begin
              if (occ == '0) begin
                res_load = 1'b1;
                res_next = make_result(32'd0, ST_EMPTY, 1'b0, occ);
              end else begin
                state_next = BK_DEQ_RD;
              end
            end
            CMD_STAT: begin
              res_load = 1'b1;
            end
            CMD_SRCH: begin
              if (occ == '0) begin
                res_load = 1'b1;
              end else begin
                key_next      = cmd_value;
                scan_idx_next = head;
                scan_cnt_next = '0;
                hit_next      = 1'b0;
                state_next    = BK_SCAN;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      BK_DEQ_RD: begin
        // head word arrives from the store this cycle
        res_load   = 1'b1;
        res_next   = make_result(rdata_ext[31:0], ST_OK, 1'b0, occ - 1'b1);
        head_next  = advance(head);
        occ_next   = occ - 1'b1;
        state_next = BK_IDLE;
      end
      BK_SCAN: begin
        // issue one read a cycle, compare the word read the cycle before
        if (scan_cnt != occ) begin
          ram_raddr     = scan_idx;
          scan_idx_next = advance(scan_idx);
          scan_cnt_next = scan_cnt + 1'b1;
          rd_pend_next  = 1'b1;
        end
        if (rd_pend && (ram_rdata == key)) begin
          hit_next = 1'b1;
        end
        if ((scan_cnt == occ) && !rd_pend) begin
          res_load   = 1'b1;
          res_next   = make_result(32'd0, ST_OK, hit, occ);
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> !res_valid)
    else $error("result pending while a command is in progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN) |-> (scan_cnt <= occ))
    else $error("search read past the stored entries");

  a_deq_moves_head: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DEQ_RD) |=> (occ == $past(occ) - 1'b1))
    else $error("dequeue did not drop the count");

endmodule

// ===== rtl/bounded_fifo_with_search_top.sv =====
// bounded_fifo_with_search_top: top level of the fifo with membership search
// depends on bfws_pkg, bfws_front, bfws_cmd_queue, bfws_back and bfws_ram
//
// Commands enter on the s_axis channel: tuser carries the op (enqueue,
// dequeue, status, search), tdata the 32-bit value. Every command gives
// exactly one result beat on m_axis, in command order. The user must write
// the fill limit on the cfg channel (always ready) only while the block is
// idle; the block itself does not enforce this. A command passes an input
// register and a two-entry queue, then the executor. Enqueue, status,
// rejected commands and a dequeue or search on an empty queue are answered
// from the idle state, a dequeue passes a read state, and a search over
// stored entries reads the store one entry a cycle through its single
// registered read port, compares the last word, then registers the result.
// The executor starts one command per pass, so commands answered from the
// idle state flow one a cycle when the receiver keeps up.
// Reset clears the pointers and count, so the queue is empty, and sets the
// limit to 16; the store itself is not cleared. When the receiver stalls,
// the result waits in the output register, the executor holds its next
// command and the front keeps accepting until the queue fills.
module bounded_fifo_with_search_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // read_value, status, found, entry_count, is_empty, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data        // queue_limit
);
  import bfws_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int QW = DATA_WIDTH + 2;

  logic                  f_valid;
  logic                  f_ready;
  cmd_kind_t             f_kind;
  logic [DATA_WIDTH-1:0] f_value;
  logic [LW-1:0]         limit_eff;
  logic                  q_valid;
  logic                  q_ready;
  logic [QW-1:0]         q_data;
  result_t               res;

  bfws_front #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .LW         (LW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd_kind      (f_kind),
    .cmd_value     (f_value),
    .limit_eff     (limit_eff)
  );

  bfws_cmd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_value, f_kind}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  bfws_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .LW         (LW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_kind  (cmd_kind_t'(q_data[1:0])),
    .cmd_value (q_data[QW-1:2]),
    .limit_eff (limit_eff),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // result beat packing
  assign m_axis_tdata = {{RESULT_PAD{1'b0}}, res};

endmodule

// ===== verif/bounded_fifo_with_search_top_tb.sv =====
// bounded_fifo_with_search_top_tb: self-checking bench for the fifo with membership search
// drives commands and limit writes, predicts every result beat, checks in order
// depends on bfws_pkg and bounded_fifo_with_search_top
module bounded_fifo_with_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfws_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 20;
  localparam int SHOWN_MAX   = 10;

  typedef struct {
    cmd_kind_t   op;
    logic [31:0] value;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // value
  logic [1:0]  s_axis_tuser = '0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // read_value, status, found, entry_count, is_empty, pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;       // queue_limit

  // mirror of the queue contents and the fill limit
  logic [31:0] held_values[$];
  logic [4:0]  fill_limit = LIMIT_RESET;

  cmd_t        cmd_backlog[$];
  cmd_t        cmd_on_bus;
  result_t     due_results[$];
  logic [31:0] recent_values[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  bounded_fifo_with_search_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // outcome of one command on the mirrored queue, updating the mirror
  function automatic result_t fifo_outcome(cmd_t cmd);
    result_t     r;
    int unsigned cap;
    r = '0;
    cap = (fill_limit > DEPTH) ? DEPTH : fill_limit;
    case (cmd.op)
      CMD_ENQ: begin
        if (held_values.size() >= cap) r.status = ST_FULL;
        else held_values.push_back(cmd.value);
      end
      CMD_DEQ: begin
        if (held_values.size() == 0) r.status = ST_EMPTY;
        else r.read_value = held_values.pop_front();
      end
      CMD_SRCH: begin
        foreach (held_values[i])
          if (held_values[i] == cmd.value) r.found = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = 5'(held_values.size());
    r.is_empty    = (held_values.size() == 0);
    return r;
  endfunction

  // command driver: predicts on every accepted beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) due_results.push_back(fifo_outcome(cmd_on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_on_bus = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cmd_on_bus.op;
          s_axis_tdata  <= cmd_on_bus.value;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= SHOWN_MAX)
      $display("%0t %s: expected rd=%h st=%0d fnd=%0b cnt=%0d emp=%0b, got rd=%h st=%0d fnd=%0b cnt=%0d emp=%0b",
               $realtime, what, want.read_value, want.status, want.found, want.entry_count,
               want.is_empty, got.read_value, got.status, got.found, got.entry_count,
               got.is_empty);
  endtask

  // result monitor: compare each accepted beat against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[RESULT_BITS-1:0];
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing due", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.read_value !== want.read_value || got.status !== want.status ||
              got.found !== want.found || got.entry_count !== want.entry_count ||
              got.is_empty !== want.is_empty)
            report_mismatch("result beat differs", want, got);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // run watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_cmd(cmd_kind_t op, logic [31:0] v);
    cmd_t c;
    c.op = op;
    c.value = v;
    cmd_backlog.push_back(c);
  endtask

  // hold the sender until every due result has come back, then settle
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] lim);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk);
    while (!cfg_ready);
    fill_limit = lim;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 15));
      3: return 32'hffff_fff0 | 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // random command, weighted toward filling or draining the queue
  task automatic queue_random_cmd(int enq_weight);
    int          roll;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    if (roll < enq_weight) begin
      v = pick_value();
      recent_values.push_back(v);
      if (recent_values.size() > 32) void'(recent_values.pop_front());
      queue_cmd(CMD_ENQ, v);
    end else if (roll < 76) begin
      queue_cmd(CMD_DEQ, pick_value());
    end else if (roll < 84) begin
      queue_cmd(CMD_STAT, pick_value());
    end else begin
      if (recent_values.size() > 0 && $urandom_range(0, 9) < 6)
        v = recent_values[$urandom_range(0, recent_values.size() - 1)];
      else
        v = pick_value();
      queue_cmd(CMD_SRCH, v);
    end
  endtask

  // stimulus sequence and final verdict
  initial begin
    int seg_limit[8] = '{3, 0, 31, 16, 9, 1, 31, 12};
    int seg_items[8] = '{80, 40, 150, 130, 120, 80, 120, 80};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 50;

    // directed: empty cases, extreme values, search hit and miss, full and wrap
    queue_cmd(CMD_STAT, 32'h0);
    queue_cmd(CMD_DEQ, 32'hffff_ffff);
    queue_cmd(CMD_SRCH, 32'h0);
    queue_cmd(CMD_ENQ, 32'h8000_0000);
    queue_cmd(CMD_ENQ, 32'h7fff_ffff);
    queue_cmd(CMD_ENQ, 32'h0);
    queue_cmd(CMD_ENQ, 32'hffff_ffff);
    queue_cmd(CMD_SRCH, 32'h7fff_ffff);
    queue_cmd(CMD_SRCH, 32'h1);
    queue_cmd(CMD_DEQ, 32'h0);
    for (int i = 1; i <= 14; i++) queue_cmd(CMD_ENQ, 32'h1111_1111 * i);
    queue_cmd(CMD_SRCH, 32'hffff_ffff);
    queue_cmd(CMD_STAT, 32'hffff_ffff);
    wait_drained();

    // random segments under different limits; the first starts below the count
    for (int s = 0; s < 8; s++) begin
      if (s == 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 37;
      end else if (s == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_limit(5'(seg_limit[s]));
      for (int i = 0; i < seg_items[s]; i++)
        queue_random_cmd(((i / 30) % 2 == 0) ? 55 : 30);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
